[design/control_surface_midi_encoder_macros.svh]
// ---------------------------------------------------------------------------
// Control surface MIDI encoder assertion macros
// Shorthand for clocked, reset-gated concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef CONTROL_SURFACE_MIDI_ENCODER_MACROS_SVH
`define CONTROL_SURFACE_MIDI_ENCODER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CSME_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define CSME_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/csme_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Control surface MIDI encoder package
// Field types, MIDI codes and the message record shared by the encoder.
// ---------------------------------------------------------------------------
package csme_pkg;

  typedef logic [3:0]  chan_t;
  typedef logic [11:0] angle_t;
  typedef logic [9:0]  sample_t;
  typedef logic [3:0]  btn_t;
  typedef logic signed [12:0] delta_t;

  // One three-byte MIDI message
  typedef struct packed {
    logic [7:0] status;
    logic [6:0] data_one;
    logic [6:0] data_two;
  } msg_t;

  // Status nibbles
  localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
  localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0] KIND_CTRL     = 4'hB;

  // Controller and note numbers
  localparam logic [6:0] CC_FADER_BASE    = 7'd16;
  localparam logic [6:0] CC_JOG           = 7'd20;
  localparam logic [6:0] CC_TOUCH         = 7'd21;
  localparam logic [6:0] CC_SENSE         = 7'd22;
  localparam logic [6:0] NOTE_TOUCH       = 7'd20;
  localparam logic [6:0] NOTE_BUTTON_BASE = 7'd21;

  localparam logic [6:0] VAL_MAX  = 7'h7F;
  localparam logic [6:0] VAL_ZERO = 7'h00;

  // Fader and button counts share one 2-bit index
  localparam int unsigned NUM_FADERS = 4;
  localparam int unsigned IDX_W      = 2;

  // Jog wrap and chunk limits
  localparam logic [11:0] ANGLE_HALF = 12'h800;
  localparam delta_t      JOG_POS    = 13'sd63;
  localparam delta_t      JOG_NEG    = -13'sd63;

  // Build a message with the channel in the low status nibble
  function automatic msg_t make_msg(logic [3:0] kind, chan_t chan,
                                    logic [6:0] d1, logic [6:0] d2);
    msg_t m;
    m.status   = {kind, chan};
    m.data_one = d1;
    m.data_two = d2;
    return m;
  endfunction

endpackage

[design/control_surface_midi_encoder.sv]
`timescale 1ns / 1ps
// Sequencing: per snapshot, a step sequencer walks the message slots and 0 to 33
//   jog chunks around one shared 13-bit subtractor, one slot per cycle while the
//   output is not stalled; no new snapshot is taken until the burst is done.
// Each message passes through the pending register and then the output register.
// Reset: asynchronous, active low; clears channel, sent-value valid bits, touch,
//   button and angle history and the valid bits of both message registers.
// ---------------------------------------------------------------------------
// Control surface MIDI encoder
// Turns one control surface snapshot into a burst of three-byte MIDI
// messages: faders, touch, sense level, buttons and jog motion chunks.
// ---------------------------------------------------------------------------
module control_surface_midi_encoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  csme_pkg::chan_t   cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  csme_pkg::angle_t  platter_angle_i,
  input  csme_pkg::sample_t crossfader_a_i,
  input  csme_pkg::sample_t crossfader_b_i,
  input  csme_pkg::sample_t volume_a_i,
  input  csme_pkg::sample_t volume_b_i,
  input  logic              touch_flag_i,
  input  csme_pkg::sample_t touch_sense_level_i,
  input  csme_pkg::btn_t    button_bits_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        status_byte_o,
  output logic [6:0]        data_one_o,
  output logic [6:0]        data_two_o,
  output logic              last_message_o
);
  import csme_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_FADER   = 4'd1;
  localparam logic [3:0] S_TLEVEL  = 4'd2;
  localparam logic [3:0] S_TNOTE   = 4'd3;
  localparam logic [3:0] S_SENSE   = 4'd4;
  localparam logic [3:0] S_BUTTON  = 4'd5;
  localparam logic [3:0] S_JOGINIT = 4'd6;
  localparam logic [3:0] S_JOG     = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  // Control state
  logic [3:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  chan_t            chan_q;
  logic [NUM_FADERS-1:0] fader_ok_q;
  logic             sense_ok_q;
  logic             touch_prior_q, touch_known_q;
  btn_t             btn_prior_q;
  angle_t           angle_prior_q;
  logic             angle_known_q;
  logic             pend_vld_q, pend_vld_d;
  logic             out_vld_q, out_vld_d;

  // Payload
  angle_t     angle_q;
  logic [6:0] fader_q      [NUM_FADERS];
  logic [6:0] fader_sent_q [NUM_FADERS];
  logic       touch_q;
  logic [6:0] sense_q, sense_sent_q;
  btn_t       btn_q;
  delta_t     delta_q;
  msg_t       pend_q, out_q;
  logic       out_last_q;

  // Datapath
  delta_t     sub_a, sub_b, sub_res, chunk, wrapped;
  logic [6:0] fv;
  logic       fader_send, sense_send, touch_send, btn_send;
  logic       gen_vld;
  msg_t       gen_msg;
  logic       out_free, advance, take;
  logic       load_pend, load_out_mid, load_out_end;

  assign in_stall_o = (state_q != S_IDLE);
  assign take       = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;

  // Clamp the remaining jog motion to one chunk
  always_comb begin
    priority if (delta_q > JOG_POS) begin
      chunk = JOG_POS;
    end else if (delta_q < JOG_NEG) begin
      chunk = JOG_NEG;
    end else begin
      chunk = delta_q;
    end
  end

  // Route operands into the shared subtractor
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    unique case (state_q)
      S_FADER: begin
        sub_a = {6'd0, fader_q[idx_q]};
        sub_b = {6'd0, fader_sent_q[idx_q]};
      end
      S_JOGINIT: begin
        sub_a = {1'b0, angle_q};
        sub_b = {1'b0, (angle_known_q ? angle_prior_q : angle_q)};
      end
      S_JOG: begin
        sub_a = delta_q;
        sub_b = chunk;
      end
      default: begin
      end
    endcase
  end

  assign sub_res = sub_a - sub_b;

  // Wrap-correct the angle step; an exact half turn keeps its sign
  assign wrapped = (sub_res[11:0] == ANGLE_HALF) ? sub_res
                                                 : {sub_res[11], sub_res[11:0]};

  // Send decisions for each slot
  assign fv         = fader_q[idx_q];
  assign fader_send = !fader_ok_q[idx_q] ||
                      ((sub_res != '0) &&
                       ((fv == VAL_ZERO) || (fv == VAL_MAX) ||
                        !((sub_res == 13'sd1) || (sub_res == -13'sd1))));
  assign touch_send = !touch_known_q || (touch_q != touch_prior_q);
  assign sense_send = !sense_ok_q || (sense_q != sense_sent_q);
  assign btn_send   = btn_q[idx_q] != btn_prior_q[idx_q];

  // Build the message for the current slot
  always_comb begin
    gen_vld = 1'b0;
    gen_msg = make_msg(KIND_CTRL, chan_q, CC_JOG, chunk[6:0]);
    unique case (state_q)
      S_FADER: begin
        gen_vld = fader_send;
        gen_msg = make_msg(KIND_CTRL, chan_q, CC_FADER_BASE + {5'd0, idx_q}, fv);
      end
      S_TLEVEL: begin
        gen_vld = 1'b1;
        gen_msg = make_msg(KIND_CTRL, chan_q, CC_TOUCH, touch_q ? VAL_MAX : VAL_ZERO);
      end
      S_TNOTE: begin
        gen_vld = touch_send;
        gen_msg = touch_q ? make_msg(KIND_NOTE_ON, chan_q, NOTE_TOUCH, VAL_MAX)
                          : make_msg(KIND_NOTE_OFF, chan_q, NOTE_TOUCH, VAL_ZERO);
      end
      S_SENSE: begin
        gen_vld = sense_send;
        gen_msg = make_msg(KIND_CTRL, chan_q, CC_SENSE, sense_q);
      end
      S_BUTTON: begin
        gen_vld = btn_send;
        gen_msg = btn_q[idx_q]
                  ? make_msg(KIND_NOTE_ON, chan_q, NOTE_BUTTON_BASE + {5'd0, idx_q},
                             VAL_MAX)
                  : make_msg(KIND_NOTE_OFF, chan_q, NOTE_BUTTON_BASE + {5'd0, idx_q},
                             VAL_ZERO);
      end
      S_JOG: begin
        gen_vld = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // A new message may enter the pending slot once the held one can move on
  assign advance      = !gen_vld || !pend_vld_q || out_free;
  assign load_pend    = gen_vld && advance;
  assign load_out_mid = load_pend && pend_vld_q;
  assign load_out_end = (state_q == S_DONE) && out_free;

  assign pend_vld_d = load_pend ? 1'b1 : (load_out_end ? 1'b0 : pend_vld_q);
  assign out_vld_d  = (load_out_mid || load_out_end) ? 1'b1 : (out_vld_q && out_stall_i);

  // Step the slot sequencer
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          state_d = S_FADER;
          idx_d   = '0;
        end
      end
      S_FADER: begin
        if (advance) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == IDX_W'(NUM_FADERS - 1)) begin
            state_d = S_TLEVEL;
          end
        end
      end
      S_TLEVEL: begin
        if (advance) state_d = S_TNOTE;
      end
      S_TNOTE: begin
        if (advance) state_d = S_SENSE;
      end
      S_SENSE: begin
        if (advance) begin
          state_d = S_BUTTON;
          idx_d   = '0;
        end
      end
      S_BUTTON: begin
        if (advance) begin
          idx_d = idx_q + 1'b1;
          if (idx_q == IDX_W'(NUM_FADERS - 1)) begin
            state_d = S_JOGINIT;
          end
        end
      end
      S_JOGINIT: begin
        state_d = (wrapped == '0) ? S_DONE : S_JOG;
      end
      S_JOG: begin
        if (advance && (sub_res == '0)) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and history registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      idx_q         <= '0;
      chan_q        <= '0;
      fader_ok_q    <= '0;
      sense_ok_q    <= 1'b0;
      touch_prior_q <= 1'b0;
      touch_known_q <= 1'b0;
      btn_prior_q   <= '0;
      angle_prior_q <= '0;
      angle_known_q <= 1'b0;
      pend_vld_q    <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) chan_q <= cfg_data_i;
      if (state_q == S_FADER && load_pend) fader_ok_q[idx_q] <= 1'b1;
      if (state_q == S_SENSE && load_pend) sense_ok_q <= 1'b1;
      if (state_q == S_TNOTE && load_pend) begin
        touch_prior_q <= touch_q;
        touch_known_q <= 1'b1;
      end
      if (state_q == S_BUTTON && advance && idx_q == IDX_W'(NUM_FADERS - 1)) begin
        btn_prior_q <= btn_q;
      end
      if (state_q == S_JOGINIT) begin
        angle_prior_q <= angle_q;
        angle_known_q <= 1'b1;
      end
    end
  end

  // Capture the snapshot and hold message payloads
  always_ff @(posedge clk_i) begin
    if (take) begin
      angle_q    <= platter_angle_i;
      fader_q[0] <= crossfader_a_i[9:3];
      fader_q[1] <= crossfader_b_i[9:3];
      fader_q[2] <= volume_a_i[9:3];
      fader_q[3] <= volume_b_i[9:3];
      touch_q    <= touch_flag_i;
      sense_q    <= touch_sense_level_i[9:3];
      btn_q      <= button_bits_i;
    end
    if (state_q == S_FADER && load_pend) fader_sent_q[idx_q] <= fv;
    if (state_q == S_SENSE && load_pend) sense_sent_q <= sense_q;
    if (state_q == S_JOGINIT) begin
      delta_q <= wrapped;
    end else if (state_q == S_JOG && advance) begin
      delta_q <= sub_res;
    end
    if (load_pend) pend_q <= gen_msg;
    if (load_out_mid || load_out_end) begin
      out_q      <= pend_q;
      out_last_q <= load_out_end;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign status_byte_o  = out_q.status;
  assign data_one_o     = out_q.data_one;
  assign data_two_o     = out_q.data_two;
  assign last_message_o = out_last_q;

endmodule

[design/csme_checker.sv]
`timescale 1ns / 1ps
`include "control_surface_midi_encoder_macros.svh"
// ---------------------------------------------------------------------------
// Control surface MIDI encoder checker
// Port-level checks of the message stream and the input handshake.
// ---------------------------------------------------------------------------
module csme_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] status_byte_o,
  input logic [6:0] data_one_o,
  input logic [6:0] data_two_o,
  input logic       last_message_o
);

  // Hold a stalled message
  `CSME_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(status_byte_o) && $stable(data_one_o) && $stable(data_two_o) && $stable(last_message_o), "stalled message changed")

  // Block the input right after a transfer in
  `CSME_ASSERT_NXT(a_busy_after_in, in_valid_i && !in_stall_o, in_stall_o, "input open after transfer")

  // Reopen the input only once the final message is out
  `CSME_ASSERT_IMP(a_free_after_last, $fell(in_stall_o), out_valid_o && last_message_o, "input reopened before final message")

endmodule

bind control_surface_midi_encoder csme_checker u_csme_checker (.*);
